// ----- sv/quad_batcher_with_texture_slots_assert.svh -----
// Assertion macros used by the checker of the quad batcher.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef QUAD_BATCHER_WITH_TEXTURE_SLOTS_ASSERT_SVH
`define QUAD_BATCHER_WITH_TEXTURE_SLOTS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define QBTS_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QBTS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/qbts_pkg.sv -----
package qbts_pkg;

   // Default sizes of the block.
   localparam int SLOT_COUNT_DEF = 32;
   localparam int MAX_QUADS_DEF  = 8192;
   localparam int ID_BITS_DEF    = 16;

   // Fixed field widths.
   localparam int LIMIT_W    = 14;
   localparam int POS_W      = 18;
   localparam int CSR_ADDR_W = 3;

   // Tiling factor of an untextured quad: 1.0 in Q8.8.
   localparam logic [15:0] TILE_ONE = 16'd256;

   // Command codes of the request channel.
   localparam logic [1:0] CMD_DRAW  = 2'd0;
   localparam logic [1:0] CMD_BEGIN = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // Result kinds.
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   // Register addresses of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_QUAD_LIMIT_ADDR = 3'd0;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EMIT
   } state_type;

   // Control part of the search token that walks the slot chain.
   typedef struct packed {
      logic valid;
      logic hit;
   } link_type;

endpackage

// ----- sv/qbts_slot_cell.sv -----
module qbts_slot_cell
   import qbts_pkg::*;
#(
   parameter int INDEX   = 1,
   parameter int SLOT_W  = 5,
   parameter int NS_W    = 6,
   parameter int ID_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  link_type           link_in,
   input  logic [ID_BITS-1:0] id_in,
   input  logic [SLOT_W-1:0]  slot_in,
   input  logic [NS_W-1:0]    next_slot,
   input  logic               wr_en,
   input  logic [SLOT_W-1:0]  wr_slot,
   input  logic [ID_BITS-1:0] wr_id,
   output link_type           link_out,
   output logic [ID_BITS-1:0] id_out,
   output logic [SLOT_W-1:0]  slot_out
);

   logic [ID_BITS-1:0] entry_ff;
   link_type           link_ff;
   link_type           link_in_next;
   logic [ID_BITS-1:0] id_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  slot_in_next;
   logic               match;

   // This slot is live only below the batch's next free slot.
   assign match = link_in.valid && (NS_W'(INDEX) < next_slot) && (entry_ff == id_in);

   // A later cell overrides an earlier hit, so the highest matching slot wins.
   always_comb begin
      link_in_next.valid = link_in.valid;
      link_in_next.hit   = link_in.hit || match;
      slot_in_next       = match ? SLOT_W'(INDEX) : slot_in;
   end

   // Token control moves one cell per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_next;
      end
   end

   // Token payload and the stored texture id.
   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      slot_ff <= slot_in_next;
      if (wr_en && (wr_slot == SLOT_W'(INDEX))) begin
         entry_ff <= wr_id;
      end
   end

   assign link_out = link_ff;
   assign id_out   = id_ff;
   assign slot_out = slot_ff;

endmodule

// ----- sv/quad_batcher_with_texture_slots.sv -----
// Sprite quad batcher with a texture slot table. A draw transaction yields four corner
// vertices, preceded by a flush transaction when the batch is full (quad_limit quads) or
// when a new texture finds every slot taken; begin empties the batch and end flushes a
// non-empty batch without emptying it. The slot table is a chain of SLOT_COUNT-1 cells; a
// textured draw sends its texture id down the chain one cell per cycle. The chain walk
// sets the rate of textured draws, the single result register that of all others. One
// item is worked at a time; the last result of an item may wait in the result register
// while the next item is accepted. Unused command code 3 is accepted and ignored.
module quad_batcher_with_texture_slots
   import qbts_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int MAX_QUADS  = MAX_QUADS_DEF,
   parameter int ID_BITS    = ID_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic                    req_textured,
   input  logic [15:0]             req_texture_id,
   input  logic [47:0]             req_axis_u,
   input  logic [47:0]             req_axis_v,
   input  logic [47:0]             req_origin,
   input  logic [31:0]             req_tint,
   input  logic [15:0]             req_tiling,
   // Result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_kind,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic signed [POS_W-1:0] rsp_pos_z,
   output logic [31:0]             rsp_color,
   output logic                    rsp_tex_u,
   output logic                    rsp_tex_v,
   output logic [4:0]              rsp_slot,
   output logic [15:0]             rsp_tile_out,
   output logic [15:0]             rsp_index_count,
   output logic [5:0]              rsp_slots_used,
   output logic                    rsp_last,
   // Configuration port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int NS_W   = $clog2(SLOT_COUNT + 1);
   localparam int CNT_W  = $clog2(MAX_QUADS + 1);
   localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int IC_W   = CNT_W + 16;
   localparam int SU_W   = NS_W + 6;
   localparam int SO_W   = SLOT_W + 5;
   localparam int IDX_W  = ID_BITS + 16;

   // Control state
   state_type          state_ff, state_in;
   logic [LIMIT_W-1:0] quad_limit_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [NS_W-1:0]    next_slot_ff, next_slot_in;
   logic               flush_pend_ff, flush_pend_in;
   logic               launch_ff, launch_in;
   logic [1:0]         corner_ff, corner_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Item payload held while it is worked
   logic [CNT_W-1:0]   flush_cnt_ff, flush_cnt_in;
   logic [NS_W-1:0]    flush_slots_ff, flush_slots_in;
   logic               draw_ff, draw_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [15:0]        tile_ff, tile_in;
   logic [47:0]        u_ff, v_ff, o_ff;
   logic [31:0]        tint_ff;
   logic [ID_BITS-1:0] id_ff;

   // Result register
   logic                    rsp_kind_ff, rsp_kind_in;
   logic signed [POS_W-1:0] rsp_pos_ff [3];
   logic signed [POS_W-1:0] rsp_pos_in [3];
   logic [31:0]             rsp_color_ff, rsp_color_in;
   logic                    rsp_tex_u_ff, rsp_tex_u_in;
   logic                    rsp_tex_v_ff, rsp_tex_v_in;
   logic [4:0]              rsp_slot_ff, rsp_slot_in;
   logic [15:0]             rsp_tile_ff, rsp_tile_in;
   logic [15:0]             rsp_index_count_ff, rsp_index_count_in;
   logic [5:0]              rsp_slots_used_ff, rsp_slots_used_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Combinational helpers
   logic               req_fire;
   logic               emit_ok;
   logic               done_load;
   logic               limit_hit;
   logic               table_full;
   logic [CMP_W-1:0]   limit_eff;
   logic [ID_BITS-1:0] req_id;
   logic [IDX_W-1:0]   req_id_ext;
   logic               corner_u, corner_v;
   logic signed [POS_W-1:0] pos_calc [3];
   logic [IC_W-1:0]    index_ext;
   logic [SU_W-1:0]    slots_ext;
   logic [SO_W-1:0]    slot_ext;
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_slot;

   // Slot chain links; link 0 is driven here, link k leaves cell k
   link_type           link [SLOT_COUNT];
   logic [ID_BITS-1:0] link_id [SLOT_COUNT];
   logic [SLOT_W-1:0]  link_slot [SLOT_COUNT];
   link_type           search_done;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign emit_ok   = !rsp_valid_ff || !rsp_stall;

   // Texture id compared on its low ID_BITS bits.
   assign req_id_ext = IDX_W'(req_texture_id);
   assign req_id     = req_id_ext[ID_BITS-1:0];

   // Batch limit, capped at MAX_QUADS; a limit of zero acts like a limit of one.
   always_comb begin
      if (CMP_W'(quad_limit_ff) > CMP_W'(MAX_QUADS)) begin
         limit_eff = CMP_W'(MAX_QUADS);
      end else begin
         limit_eff = CMP_W'(quad_limit_ff);
      end
      limit_hit  = (CMP_W'(count_ff) >= limit_eff);
      table_full = (next_slot_ff >= NS_W'(SLOT_COUNT));
   end

   // An item is finished when its last result enters the result register.
   assign done_load = emit_ok && (flush_pend_ff ? !draw_ff : (corner_ff == 2'd3));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         quad_limit_ff <= LIMIT_W'(MAX_QUADS);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == CSR_QUAD_LIMIT_ADDR)) begin
         quad_limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_QUAD_LIMIT_ADDR) ? 32'(quad_limit_ff) : '0;

   // Slot table chain.
   assign link[0].valid = launch_ff;
   assign link[0].hit   = 1'b0;
   assign link_id[0]    = id_ff;
   assign link_slot[0]  = '0;

   for (genvar k = 1; k < SLOT_COUNT; k++) begin : g_cell
      qbts_slot_cell #(
         .INDEX   (k),
         .SLOT_W  (SLOT_W),
         .NS_W    (NS_W),
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .link_in   (link[k-1]),
         .id_in     (link_id[k-1]),
         .slot_in   (link_slot[k-1]),
         .next_slot (next_slot_ff),
         .wr_en     (wr_en),
         .wr_slot   (wr_slot),
         .wr_id     (id_ff),
         .link_out  (link[k]),
         .id_out    (link_id[k]),
         .slot_out  (link_slot[k])
      );
   end

   assign search_done = link[SLOT_COUNT-1];

   // A miss claims the next free slot, or slot 1 after the table-full flush.
   assign wr_en   = (state_ff == ST_SEARCH) && search_done.valid && !search_done.hit;
   assign wr_slot = table_full ? SLOT_W'(1) : next_slot_ff[SLOT_W-1:0];

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_command == CMD_DRAW)) begin
               state_in = req_textured ? ST_SEARCH : ST_EMIT;
            end else if (req_fire && (req_command == CMD_END) && (count_ff != '0)) begin
               state_in = ST_EMIT;
            end
         end
         ST_SEARCH: begin
            if (search_done.valid) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (done_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Batch state and item registers driven by the sequencer.
   always_comb begin
      count_in       = count_ff;
      next_slot_in   = next_slot_ff;
      flush_pend_in  = flush_pend_ff;
      flush_cnt_in   = flush_cnt_ff;
      flush_slots_in = flush_slots_ff;
      launch_in      = 1'b0;
      corner_in      = corner_ff;
      draw_in        = draw_ff;
      slot_in        = slot_ff;
      tile_in        = tile_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_command)
                  CMD_DRAW: begin
                     // The limit flush comes first and empties the batch.
                     draw_in        = 1'b1;
                     corner_in      = 2'd0;
                     flush_pend_in  = limit_hit && (count_ff != '0);
                     flush_cnt_in   = count_ff;
                     flush_slots_in = next_slot_ff;
                     if (limit_hit) begin
                        next_slot_in = NS_W'(1);
                     end
                     if (req_textured) begin
                        launch_in = 1'b1;
                        tile_in   = req_tiling;
                        count_in  = limit_hit ? '0 : count_ff;
                     end else begin
                        slot_in  = '0;
                        tile_in  = TILE_ONE;
                        count_in = limit_hit ? CNT_W'(1) : count_ff + CNT_W'(1);
                     end
                  end
                  CMD_BEGIN: begin
                     count_in     = '0;
                     next_slot_in = NS_W'(1);
                  end
                  CMD_END: begin
                     draw_in        = 1'b0;
                     flush_pend_in  = (count_ff != '0);
                     flush_cnt_in   = count_ff;
                     flush_slots_in = next_slot_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (search_done.valid) begin
               if (search_done.hit) begin
                  slot_in  = link_slot[SLOT_COUNT-1];
                  count_in = count_ff + CNT_W'(1);
               end else if (table_full) begin
                  // No free slot: flush, then the quad opens a new batch in slot 1.
                  flush_pend_in  = (count_ff != '0);
                  flush_cnt_in   = count_ff;
                  flush_slots_in = next_slot_ff;
                  slot_in        = SLOT_W'(1);
                  next_slot_in   = NS_W'(2);
                  count_in       = CNT_W'(1);
               end else begin
                  slot_in      = next_slot_ff[SLOT_W-1:0];
                  next_slot_in = next_slot_ff + NS_W'(1);
                  count_in     = count_ff + CNT_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               if (flush_pend_ff) begin
                  flush_pend_in = 1'b0;
               end else begin
                  corner_in = corner_ff + 2'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Corner position: 2*origin +- axis_u +- axis_v, exact in Q9.9.
   always_comb begin
      logic signed [POS_W-1:0] o_e, u_e, v_e;
      o_e = '0;
      u_e = '0;
      v_e = '0;
      corner_u = (corner_ff == 2'd1) || (corner_ff == 2'd2);
      corner_v = corner_ff[1];
      for (int k = 0; k < 3; k++) begin
         o_e = POS_W'(signed'(o_ff[16*k +: 16]));
         u_e = POS_W'(signed'(u_ff[16*k +: 16]));
         v_e = POS_W'(signed'(v_ff[16*k +: 16]));
         pos_calc[k] = (o_e <<< 1) + (corner_u ? u_e : -u_e) + (corner_v ? v_e : -v_e);
      end
   end

   // Flush counts and the vertex slot, cut to the result widths.
   assign index_ext = (IC_W'(flush_cnt_ff) << 2) + (IC_W'(flush_cnt_ff) << 1);
   assign slots_ext = SU_W'(flush_slots_ff);
   assign slot_ext  = SO_W'(slot_ff);

   // Next content of the result register.
   always_comb begin
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_kind_in        = rsp_kind_ff;
      rsp_pos_in         = rsp_pos_ff;
      rsp_color_in       = rsp_color_ff;
      rsp_tex_u_in       = rsp_tex_u_ff;
      rsp_tex_v_in       = rsp_tex_v_ff;
      rsp_slot_in        = rsp_slot_ff;
      rsp_tile_in        = rsp_tile_ff;
      rsp_index_count_in = rsp_index_count_ff;
      rsp_slots_used_in  = rsp_slots_used_ff;
      rsp_last_in        = rsp_last_ff;
      if ((state_ff == ST_EMIT) && emit_ok) begin
         rsp_valid_in = 1'b1;
         if (flush_pend_ff) begin
            rsp_kind_in        = KIND_FLUSH;
            rsp_pos_in         = '{default: '0};
            rsp_color_in       = '0;
            rsp_tex_u_in       = 1'b0;
            rsp_tex_v_in       = 1'b0;
            rsp_slot_in        = '0;
            rsp_tile_in        = '0;
            rsp_index_count_in = index_ext[15:0];
            rsp_slots_used_in  = slots_ext[5:0];
            rsp_last_in        = !draw_ff;
         end else begin
            rsp_kind_in        = KIND_VERTEX;
            rsp_pos_in         = pos_calc;
            rsp_color_in       = tint_ff;
            rsp_tex_u_in       = corner_u;
            rsp_tex_v_in       = corner_v;
            rsp_slot_in        = slot_ext[4:0];
            rsp_tile_in        = tile_ff;
            rsp_index_count_in = '0;
            rsp_slots_used_in  = '0;
            rsp_last_in        = (corner_ff == 2'd3);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         next_slot_ff  <= NS_W'(1);
         flush_pend_ff <= 1'b0;
         launch_ff     <= 1'b0;
         corner_ff     <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_slot_ff  <= next_slot_in;
         flush_pend_ff <= flush_pend_in;
         launch_ff     <= launch_in;
         corner_ff     <= corner_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      flush_cnt_ff       <= flush_cnt_in;
      flush_slots_ff     <= flush_slots_in;
      draw_ff            <= draw_in;
      slot_ff            <= slot_in;
      tile_ff            <= tile_in;
      if (req_fire) begin
         u_ff    <= req_axis_u;
         v_ff    <= req_axis_v;
         o_ff    <= req_origin;
         tint_ff <= req_tint;
         id_ff   <= req_id;
      end
      rsp_kind_ff        <= rsp_kind_in;
      rsp_pos_ff         <= rsp_pos_in;
      rsp_color_ff       <= rsp_color_in;
      rsp_tex_u_ff       <= rsp_tex_u_in;
      rsp_tex_v_ff       <= rsp_tex_v_in;
      rsp_slot_ff        <= rsp_slot_in;
      rsp_tile_ff        <= rsp_tile_in;
      rsp_index_count_ff <= rsp_index_count_in;
      rsp_slots_used_ff  <= rsp_slots_used_in;
      rsp_last_ff        <= rsp_last_in;
   end

   // Result channel outputs.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_pos_x       = rsp_pos_ff[0];
   assign rsp_pos_y       = rsp_pos_ff[1];
   assign rsp_pos_z       = rsp_pos_ff[2];
   assign rsp_color       = rsp_color_ff;
   assign rsp_tex_u       = rsp_tex_u_ff;
   assign rsp_tex_v       = rsp_tex_v_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_tile_out    = rsp_tile_ff;
   assign rsp_index_count = rsp_index_count_ff;
   assign rsp_slots_used  = rsp_slots_used_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- sv/qbts_checker.sv -----
`include "quad_batcher_with_texture_slots_assert.svh"

module qbts_checker
   import qbts_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_kind,
   input logic signed [POS_W-1:0] rsp_pos_x,
   input logic [31:0]             rsp_color,
   input logic                    rsp_tex_u,
   input logic                    rsp_tex_v,
   input logic [4:0]              rsp_slot,
   input logic [15:0]             rsp_tile_out,
   input logic [15:0]             rsp_index_count,
   input logic [5:0]              rsp_slots_used,
   input logic                    rsp_last
);

   // A stalled result transaction holds.
   `QBTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_pos_x) && $stable(rsp_last), "stalled result changed")

   // A flush carries only its counts, and never an empty batch.
   `QBTS_ASSERT_IMPL(a_flush_clean, rsp_valid && (rsp_kind == KIND_FLUSH), (rsp_pos_x == '0) && (rsp_color == '0) && (rsp_slot == '0) && (rsp_tile_out == '0) && (rsp_index_count != '0), "flush result malformed")

   // The last vertex of a quad is the corner at u 0, v 1.
   `QBTS_ASSERT_IMPL(a_last_corner, rsp_valid && (rsp_kind == KIND_VERTEX) && rsp_last, !rsp_tex_u && rsp_tex_v && (rsp_index_count == '0) && (rsp_slots_used == '0), "quad ended on wrong corner")

   // A flush ahead of a quad is followed at once by that quad's first vertex.
   `QBTS_ASSERT_NEXT(a_flush_then_vertex, rsp_valid && !rsp_stall && (rsp_kind == KIND_FLUSH) && !rsp_last, rsp_valid && (rsp_kind == KIND_VERTEX) && !rsp_tex_u && !rsp_tex_v, "flush not followed by vertex")

endmodule

bind quad_batcher_with_texture_slots qbts_checker u_qbts_checker (.*);

// ----- tb/tb_quad_batcher_with_texture_slots.sv -----
`timescale 1ns / 1ps

module tb_quad_batcher_with_texture_slots;
   import qbts_pkg::*;

   // Command code 3 is not defined by the block and must be ignored.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 60;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 16;

   localparam logic [47:0] HALVES_MAX = 48'h7FFF_7FFF_7FFF;
   localparam logic [47:0] HALVES_MIN = 48'h8000_8000_8000;

   typedef struct {
      logic [1:0]  command;
      logic        textured;
      logic [15:0] texture_id;
      logic [47:0] axis_u;
      logic [47:0] axis_v;
      logic [47:0] origin;
      logic [31:0] tint;
      logic [15:0] tiling;
   } sprite_cmd_type;

   typedef struct {
      logic                    kind;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [31:0]             color;
      logic                    tex_u;
      logic                    tex_v;
      logic [4:0]              slot;
      logic [15:0]             tile_out;
      logic [15:0]             index_count;
      logic [5:0]              slots_used;
      logic                    last;
   } batch_out_type;

   // Tracks the batch and slot table, and holds the vertices and flushes still owed.
   class batch_tracker;
      batch_out_type      awaited[$];
      batch_out_type      staged[$];
      logic [LIMIT_W-1:0] quad_limit;
      int                 quad_count;
      int                 next_slot;
      logic [15:0]        slot_ids[SLOT_COUNT_DEF];
      int                 errors;
      int                 commands_seen;
      int                 outputs_seen;
      int                 flushes_seen;

      function new();
         quad_limit    = LIMIT_W'(MAX_QUADS_DEF);
         quad_count    = 0;
         next_slot     = 1;
         errors        = 0;
         commands_seen = 0;
         outputs_seen  = 0;
         flushes_seen  = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         quad_limit = value;
      endfunction

      function void start_batch();
         quad_count = 0;
         next_slot  = 1;
      endfunction

      // An empty batch produces no flush transaction.
      function void stage_flush();
         batch_out_type r;
         if (quad_count == 0) return;
         r             = '{default: '0};
         r.kind        = KIND_FLUSH;
         r.index_count = 16'(quad_count * 6);
         r.slots_used  = 6'(next_slot);
         staged.push_back(r);
      endfunction

      // Corner position in Q9.9: twice the origin plus or minus each axis.
      function logic signed [POS_W-1:0] corner_pos(sprite_cmd_type c, int k, bit up, bit vp);
         logic signed [15:0] o;
         logic signed [15:0] u;
         logic signed [15:0] v;
         int                 p;
         o = c.origin[16*k +: 16];
         u = c.axis_u[16*k +: 16];
         v = c.axis_v[16*k +: 16];
         p = 2 * int'(o) + (up ? int'(u) : -int'(u)) + (vp ? int'(v) : -int'(v));
         return POS_W'(p);
      endfunction

      function void stage_draw(sprite_cmd_type c);
         batch_out_type r;
         logic [4:0]    slot;
         logic [15:0]   tile;
         int            lim;
         bit            up;
         bit            vp;
         slot = '0;
         tile = TILE_ONE;
         lim  = (quad_limit > MAX_QUADS_DEF) ? MAX_QUADS_DEF : int'(quad_limit);
         // The quad limit is checked before the slot table.
         if (quad_count >= lim) begin
            stage_flush();
            start_batch();
         end
         if (c.textured) begin
            tile = c.tiling;
            for (int i = 1; i < next_slot && i < SLOT_COUNT_DEF; i++)
               if (slot_ids[i] == c.texture_id) slot = 5'(i);
            // A miss binds the next slot, flushing first when the table is full.
            if (slot == 0) begin
               if (next_slot >= SLOT_COUNT_DEF) begin
                  stage_flush();
                  start_batch();
               end
               slot = 5'(next_slot);
               slot_ids[next_slot] = c.texture_id;
               next_slot++;
            end
         end
         // Corners come in the order (0,0), (1,0), (1,1), (0,1).
         for (int corner = 0; corner < 4; corner++) begin
            up         = (corner == 1 || corner == 2);
            vp         = (corner >= 2);
            r          = '{default: '0};
            r.kind     = KIND_VERTEX;
            r.pos_x    = corner_pos(c, 0, up, vp);
            r.pos_y    = corner_pos(c, 1, up, vp);
            r.pos_z    = corner_pos(c, 2, up, vp);
            r.color    = c.tint;
            r.tex_u    = up;
            r.tex_v    = vp;
            r.slot     = slot;
            r.tile_out = tile;
            staged.push_back(r);
         end
         quad_count++;
      endfunction

      // Called for every accepted input transaction.
      function void accept_command(sprite_cmd_type c);
         batch_out_type r;
         staged.delete();
         commands_seen++;
         case (c.command)
            CMD_DRAW:  stage_draw(c);
            CMD_BEGIN: start_batch();
            CMD_END:   stage_flush();
            default:   ;
         endcase
         if (staged.size() > 0) begin
            r      = staged.pop_back();
            r.last = 1'b1;
            staged.push_back(r);
         end
         foreach (staged[i]) awaited.push_back(staged[i]);
      endfunction

      function void compare(string name, logic signed [63:0] want, logic signed [63:0] got);
         if (want !== got) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      // Called for every accepted result transaction.
      function void check_output(batch_out_type got);
         batch_out_type want;
         outputs_seen++;
         if (awaited.size() == 0) begin
            errors++;
            $error("unexpected result transaction of kind %0d", got.kind);
            return;
         end
         want = awaited.pop_front();
         if (want.kind == KIND_FLUSH) flushes_seen++;
         compare("kind", want.kind, got.kind);
         compare("pos_x", want.pos_x, got.pos_x);
         compare("pos_y", want.pos_y, got.pos_y);
         compare("pos_z", want.pos_z, got.pos_z);
         compare("color", want.color, got.color);
         compare("tex_u", want.tex_u, got.tex_u);
         compare("tex_v", want.tex_v, got.tex_v);
         compare("slot", want.slot, got.slot);
         compare("tile_out", want.tile_out, got.tile_out);
         compare("index_count", want.index_count, got.index_count);
         compare("slots_used", want.slots_used, got.slots_used);
         compare("last", want.last, got.last);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [1:0]              req_command;
   logic                    req_textured;
   logic [15:0]             req_texture_id;
   logic [47:0]             req_axis_u;
   logic [47:0]             req_axis_v;
   logic [47:0]             req_origin;
   logic [31:0]             req_tint;
   logic [15:0]             req_tiling;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_kind;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_y;
   logic signed [POS_W-1:0] rsp_pos_z;
   logic [31:0]             rsp_color;
   logic                    rsp_tex_u;
   logic                    rsp_tex_v;
   logic [4:0]              rsp_slot;
   logic [15:0]             rsp_tile_out;
   logic [15:0]             rsp_index_count;
   logic [5:0]              rsp_slots_used;
   logic                    rsp_last;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [31:0]             csr_pwdata;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   batch_tracker tracker = new();
   bit           hold_request = 1'b0;
   bit           calm = 1'b0;
   int           limit_settings = 0;

   quad_batcher_with_texture_slots dut (.*);

   always #5 clock = ~clock;

   // Both channels are sampled mid-cycle, when nothing can change before the next edge.
   always @(negedge clock) begin : monitor
      sprite_cmd_type c;
      batch_out_type  r;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            c.command    = req_command;
            c.textured   = req_textured;
            c.texture_id = req_texture_id;
            c.axis_u     = req_axis_u;
            c.axis_v     = req_axis_v;
            c.origin     = req_origin;
            c.tint       = req_tint;
            c.tiling     = req_tiling;
            tracker.accept_command(c);
         end
         if (rsp_valid && !rsp_stall) begin
            r.kind        = rsp_kind;
            r.pos_x       = rsp_pos_x;
            r.pos_y       = rsp_pos_y;
            r.pos_z       = rsp_pos_z;
            r.color       = rsp_color;
            r.tex_u       = rsp_tex_u;
            r.tex_v       = rsp_tex_v;
            r.slot        = rsp_slot;
            r.tile_out    = rsp_tile_out;
            r.index_count = rsp_index_count;
            r.slots_used  = rsp_slots_used;
            r.last        = rsp_last;
            tracker.check_output(r);
         end
      end
   end

   // Ends the run when no transaction moves for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: random stall bursts, one long hold on request, none when calm.
   initial begin
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   function automatic sprite_cmd_type make_cmd(logic [1:0] command, logic textured,
                                               logic [15:0] id);
      sprite_cmd_type c;
      logic [63:0]    w;
      c.command    = command;
      c.textured   = textured;
      c.texture_id = id;
      w            = {$urandom(), $urandom()};
      c.axis_u     = w[47:0];
      w            = {$urandom(), $urandom()};
      c.axis_v     = w[47:0];
      w            = {$urandom(), $urandom()};
      c.origin     = w[47:0];
      c.tint       = $urandom();
      c.tiling     = 16'($urandom());
      return c;
   endfunction

   // Offers one transaction and returns at the edge where it is taken.
   task automatic send(sprite_cmd_type c);
      int gap;
      bit taken;
      gap   = 0;
      taken = 1'b0;
      if (!calm && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= c.command;
      req_textured   <= c.textured;
      req_texture_id <= c.texture_id;
      req_axis_u     <= c.axis_u;
      req_axis_v     <= c.axis_v;
      req_origin     <= c.origin;
      req_tint       <= c.tint;
      req_tiling     <= c.tiling;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
   endtask

   // Stops offering, lets every owed result drain, then writes and reads back the limit.
   task automatic reconfigure(logic [31:0] value);
      req_valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_QUAD_LIMIT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tracker.set_limit(value[LIMIT_W-1:0]);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata[LIMIT_W-1:0] !== value[LIMIT_W-1:0]) begin
         tracker.errors++;
         $error("quad_limit readback: expected %0d, got %0d",
                value[LIMIT_W-1:0], csr_prdata[LIMIT_W-1:0]);
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      limit_settings++;
   endtask

   // Mostly scenes of draws over a texture pool; sometimes a pool large enough
   // to overflow the slot table; the rest single random transactions.
   task automatic run_phase(int budget, bit open_big);
      int             sent;
      int             pool_n;
      int             len;
      bit             big;
      logic [15:0]    pool[$];
      sprite_cmd_type c;
      sent = 0;
      big  = open_big;
      while (sent < budget) begin
         if (big || $urandom_range(0, 3) != 0) begin
            if (!big) big = ($urandom_range(0, 7) == 0);
            pool_n = big ? $urandom_range(33, 40) : $urandom_range(1, 5);
            pool.delete();
            repeat (pool_n) pool.push_back(16'($urandom()));
            len = big ? pool_n : $urandom_range(3, 12);
            send(make_cmd(CMD_BEGIN, 1'($urandom_range(0, 1)), 16'($urandom())));
            sent++;
            for (int j = 0; j < len; j++) begin
               if (big)
                  send(make_cmd(CMD_DRAW, 1'b1, pool[j]));
               else if ($urandom_range(0, 4) != 0)
                  send(make_cmd(CMD_DRAW, 1'b1, pool[$urandom_range(0, pool_n - 1)]));
               else
                  send(make_cmd(CMD_DRAW, 1'b0, 16'($urandom())));
               sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
               send(make_cmd(CMD_END, 1'($urandom_range(0, 1)), 16'($urandom())));
               sent++;
            end
            big = 1'b0;
         end else begin
            c = make_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         16'($urandom()));
            send(c);
            if (c.command != CMD_UNUSED) sent++;
         end
      end
   endtask

   initial begin
      sprite_cmd_type c;
      int             phase_limits[9];
      phase_limits = '{8192, 1, 0, 31, 3, 16383, 40, 5, 0};
      phase_limits[8] = $urandom_range(1, 64);

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_command    <= CMD_DRAW;
      req_textured   <= 1'b0;
      req_texture_id <= '0;
      req_axis_u     <= '0;
      req_axis_v     <= '0;
      req_origin     <= '0;
      req_tint       <= '0;
      req_tiling     <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset limit: position extremes, hits and misses,
      // end keeping the batch, the unused code, and an end on an empty batch.
      c = make_cmd(CMD_DRAW, 1'b0, 16'hFFFF);
      c.axis_u = HALVES_MAX; c.axis_v = HALVES_MAX; c.origin = HALVES_MAX;
      c.tint = 32'hFFFF_FFFF; c.tiling = 16'hFFFF;
      send(c);
      c = make_cmd(CMD_DRAW, 1'b0, 16'h0000);
      c.axis_u = HALVES_MIN; c.axis_v = HALVES_MIN; c.origin = HALVES_MIN;
      c.tint = 32'h0; c.tiling = 16'h0;
      send(c);
      c = make_cmd(CMD_DRAW, 1'b1, 16'hFFFF);
      c.axis_u = HALVES_MIN; c.axis_v = HALVES_MAX; c.origin = HALVES_MAX;
      c.tiling = 16'hFFFF;
      send(c);
      c = make_cmd(CMD_DRAW, 1'b1, 16'h0000);
      c.axis_u = HALVES_MAX; c.axis_v = HALVES_MIN; c.origin = HALVES_MIN;
      c.tiling = 16'h0;
      send(c);
      send(make_cmd(CMD_DRAW, 1'b1, 16'hFFFF));
      send(make_cmd(CMD_END, 1'b0, 16'h0));
      send(make_cmd(CMD_DRAW, 1'b0, 16'h0));
      send(make_cmd(CMD_END, 1'b1, 16'hFFFF));
      send(make_cmd(CMD_UNUSED, 1'b1, 16'($urandom())));
      send(make_cmd(CMD_BEGIN, 1'b0, 16'h0));
      send(make_cmd(CMD_END, 1'b0, 16'h0));
      send(make_cmd(CMD_DRAW, 1'b1, 16'h1234));
      send(make_cmd(CMD_BEGIN, 1'b1, 16'h0));

      // Limit of one: a flush ahead of every quad after the first.
      reconfigure(32'd1);
      send(make_cmd(CMD_DRAW, 1'b0, 16'h0));
      send(make_cmd(CMD_DRAW, 1'b1, 16'hA5A5));
      send(make_cmd(CMD_DRAW, 1'b1, 16'hA5A5));
      send(make_cmd(CMD_END, 1'b0, 16'h0));

      // A zero limit behaves like one.
      reconfigure(32'd0);
      send(make_cmd(CMD_DRAW, 1'b0, 16'h0));
      send(make_cmd(CMD_DRAW, 1'b1, 16'h5A5A));
      send(make_cmd(CMD_END, 1'b0, 16'h0));

      // A limit above the maximum is clamped.
      reconfigure(32'd16383);
      send(make_cmd(CMD_DRAW, 1'b0, 16'h0));
      send(make_cmd(CMD_DRAW, 1'b1, 16'h0F0F));
      send(make_cmd(CMD_END, 1'b0, 16'h0));
      send(make_cmd(CMD_BEGIN, 1'b0, 16'h0));

      // Random part, one phase per limit; the first one also backs up the block.
      foreach (phase_limits[p]) begin
         reconfigure(32'(phase_limits[p]));
         if (p == 0) hold_request = 1'b1;
         if (p == 8) calm = 1'b1;
         run_phase(PHASE_ITEMS, phase_limits[p] >= 31);
      end

      req_valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Accepted %0d input transactions and checked %0d result transactions (%0d flushes)",
               tracker.commands_seen, tracker.outputs_seen, tracker.flushes_seen);
      $display("over %0d quad_limit settings, with slot-table overflow and back-pressure.",
               limit_settings);
      if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
